// ----- hdl/ffca_pkg.sv -----
// package for the first-fit coalescing allocator
// holds heap geometry constants, status codes and the request/response item types
// no dependencies
`timescale 1ns / 1ps

package ffca_pkg;

  localparam int unsigned HEAP_BYTES    = 4096;
  localparam int unsigned GRANULE_BYTES = 8;
  localparam int unsigned GRAN_SHIFT    = $clog2(GRANULE_BYTES);
  localparam int unsigned NGRAN         = HEAP_BYTES / GRANULE_BYTES;
  localparam int unsigned IDX_W         = $clog2(NGRAN);
  localparam int unsigned PTR_W         = IDX_W + 1;
  localparam int unsigned SZ_W          = PTR_W;
  localparam int unsigned REQ_W         = 16;
  localparam int unsigned ADDR_W        = 12;
  localparam int unsigned NEED_W        = REQ_W + 2 - GRAN_SHIFT;
  localparam int unsigned MIN_GRAN      = 2;

  localparam logic [PTR_W-1:0] LIST_END = PTR_W'(NGRAN);

  typedef enum logic [1:0] {
    ST_GRANTED = 2'd0,
    ST_FAILED  = 2'd1,
    ST_FREED   = 2'd2,
    ST_IGNORED = 2'd3
  } status_e;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_e;

  typedef struct packed {
    logic              req_type;
    logic [REQ_W-1:0]  req_size;
    logic [ADDR_W-1:0] ptr_offset;
    logic              has_pointer;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] user_offset;
  } rsp_t;

endpackage

// ----- hdl/first_fit_coalescing_allocator.sv -----
// first-fit coalescing heap allocator: sequencer, free-list memories, result register
// depends on ffca_pkg
`timescale 1ns / 1ps

// usage
// - one request item is taken at a rising edge with start high and busy low
// - allocate: walks the address-ordered free list first fit, splits a block when
//   at least two granules would remain, answers with the user offset
// - free: checks the offset is the start of an allocated block, walks the list to
//   the insertion point, links the block in and merges with both neighbours
// - one response item per request, shown on rsp_o for one cycle with done_o high;
//   the receiver cannot hold it off, busy is low again in that same cycle
// - order of work: a zero-size allocate or a free rejected on its address is answered
//   straight from idle, a free of a block not allocated once its flag is read; an
//   allocate reads and checks each list node visited and ends on an exact fit, on a
//   split with a further write state, or when the list runs out; a free walks the
//   nodes in front of the block, then inserts, links and merges with each neighbour;
//   the list memories have a single read port, so node lookups go one at a time
// - reset: busy stays high while a clearing pass resets the allocated flags of all
//   NGRAN granules (512 at the default heap) and writes the single whole-heap block
// - block sizes are held in granules; links use NGRAN as the end-of-list marker
module first_fit_coalescing_allocator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  ffca_pkg::req_t req_i,
  output logic          done_o,
  output ffca_pkg::rsp_t rsp_o
);

  localparam int unsigned IW = ffca_pkg::IDX_W;
  localparam int unsigned PW = ffca_pkg::PTR_W;
  localparam int unsigned SW = ffca_pkg::SZ_W;
  localparam int unsigned NW = ffca_pkg::NEED_W;

  // one-hot sequencer
  typedef enum logic [11:0] {
    S_CLR   = 12'b0000_0000_0001,
    S_IDLE  = 12'b0000_0000_0010,
    S_A_RD  = 12'b0000_0000_0100,
    S_A_CHK = 12'b0000_0000_1000,
    S_A_SPL = 12'b0000_0001_0000,
    S_F_CHK = 12'b0000_0010_0000,
    S_F_RD  = 12'b0000_0100_0000,
    S_F_NX  = 12'b0000_1000_0000,
    S_F_INS = 12'b0001_0000_0000,
    S_F_LNK = 12'b0010_0000_0000,
    S_F_MP  = 12'b0100_0000_0000,
    S_F_MC  = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [IW-1:0] cnt_q, cnt_d;
  logic [PW-1:0] head_q, head_d;
  logic [PW-1:0] cur_q, cur_d;
  logic [PW-1:0] pred_q, pred_d;
  logic [PW-1:0] g_q, g_d;
  logic [PW-1:0] rest_q, rest_d;
  logic [NW-1:0] need_q, need_d;
  logic [SW-1:0] szg_q, szg_d;
  logic          done_q, done_d;
  ffca_pkg::rsp_t rsp_q, rsp_d;

  // list memories: block size, next link, allocated flag
  logic [SW-1:0] size_mem [ffca_pkg::NGRAN];
  logic [PW-1:0] next_mem [ffca_pkg::NGRAN];
  logic          flag_mem [ffca_pkg::NGRAN];

  logic [IW-1:0] rd_idx;
  logic [SW-1:0] sz_rd;
  logic [PW-1:0] nx_rd;
  logic          fl_rd;

  logic          sz_we, nx_we, fl_we;
  logic [IW-1:0] sz_wa, nx_wa, fl_wa;
  logic [SW-1:0] sz_wd;
  logic [PW-1:0] nx_wd;
  logic          fl_wd;

  // request decode
  logic [ffca_pkg::REQ_W:0] need_sum;
  logic [NW-1:0]            need_calc;
  logic [ffca_pkg::ADDR_W-1:0] g_calc;
  logic                     addr_bad;
  logic [31:0]              rest_calc;

  assign need_sum  = (ffca_pkg::REQ_W+1)'(req_i.req_size)
                   + (ffca_pkg::REQ_W+1)'(2 * ffca_pkg::GRANULE_BYTES - 1);
  assign need_calc = (NW'(need_sum >> ffca_pkg::GRAN_SHIFT) < NW'(ffca_pkg::MIN_GRAN))
                   ? NW'(ffca_pkg::MIN_GRAN) : NW'(need_sum >> ffca_pkg::GRAN_SHIFT);

  assign addr_bad = (32'(req_i.ptr_offset) < ffca_pkg::GRANULE_BYTES)
                 || (req_i.ptr_offset[ffca_pkg::GRAN_SHIFT-1:0] != '0);
  assign g_calc   = (req_i.ptr_offset - ffca_pkg::ADDR_W'(ffca_pkg::GRANULE_BYTES))
                    >> ffca_pkg::GRAN_SHIFT;

  assign rest_calc = 32'(cur_q) + 32'(need_q);

  // user offset of a block start: header granule past it
  function automatic logic [ffca_pkg::ADDR_W-1:0] user_off(input logic [PW-1:0] blk);
    user_off = ffca_pkg::ADDR_W'((32'(blk) << ffca_pkg::GRAN_SHIFT)
                                 + ffca_pkg::GRANULE_BYTES);
  endfunction

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    head_d  = head_q;
    cur_d   = cur_q;
    pred_d  = pred_q;
    g_d     = g_q;
    rest_d  = rest_q;
    need_d  = need_q;
    szg_d   = szg_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    rd_idx  = cur_q[IW-1:0];
    sz_we   = 1'b0;
    sz_wa   = '0;
    sz_wd   = '0;
    nx_we   = 1'b0;
    nx_wa   = '0;
    nx_wd   = '0;
    fl_we   = 1'b0;
    fl_wa   = '0;
    fl_wd   = 1'b0;

    case (state_q)
      S_CLR: begin
        // clearing pass after reset, one granule a cycle
        fl_we = 1'b1;
        fl_wa = cnt_q;
        if (cnt_q == '0) begin
          sz_we = 1'b1;
          sz_wd = SW'(ffca_pkg::NGRAN);
          nx_we = 1'b1;
          nx_wd = ffca_pkg::LIST_END;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == IW'(ffca_pkg::NGRAN - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          if (req_i.req_type == ffca_pkg::REQ_ALLOC) begin
            if (req_i.req_size == '0) begin
              done_d = 1'b1;
              rsp_d  = '{status: ffca_pkg::ST_FAILED, user_offset: '0};
            end else begin
              need_d  = need_calc;
              cur_d   = head_q;
              pred_d  = ffca_pkg::LIST_END;
              state_d = S_A_RD;
            end
          end else if (!req_i.has_pointer || addr_bad
                       || 32'(g_calc) >= ffca_pkg::NGRAN) begin
            done_d = 1'b1;
            rsp_d  = '{status: ffca_pkg::ST_IGNORED, user_offset: '0};
          end else begin
            g_d     = PW'(g_calc);
            rd_idx  = IW'(g_calc);
            state_d = S_F_CHK;
          end
        end
      end

      S_A_RD: begin
        if (cur_q == ffca_pkg::LIST_END) begin
          done_d  = 1'b1;
          rsp_d   = '{status: ffca_pkg::ST_FAILED, user_offset: '0};
          state_d = S_IDLE;
        end else begin
          rd_idx  = cur_q[IW-1:0];
          state_d = S_A_CHK;
        end
      end

      S_A_CHK: begin
        if (32'(sz_rd) >= 32'(need_q) + ffca_pkg::MIN_GRAN) begin
          if (rest_calc >= ffca_pkg::NGRAN) begin
            done_d  = 1'b1;
            rsp_d   = '{status: ffca_pkg::ST_FAILED, user_offset: '0};
            state_d = S_IDLE;
          end else begin
            // split: remainder becomes a new free block
            sz_we   = 1'b1;
            sz_wa   = IW'(rest_calc);
            sz_wd   = SW'(32'(sz_rd) - 32'(need_q));
            nx_we   = 1'b1;
            nx_wa   = IW'(rest_calc);
            nx_wd   = nx_rd;
            fl_we   = 1'b1;
            fl_wa   = cur_q[IW-1:0];
            fl_wd   = 1'b1;
            rest_d  = PW'(rest_calc);
            state_d = S_A_SPL;
          end
        end else if (32'(sz_rd) >= 32'(need_q)) begin
          // whole block handed out
          if (pred_q == ffca_pkg::LIST_END) begin
            head_d = nx_rd;
          end else begin
            nx_we = 1'b1;
            nx_wa = pred_q[IW-1:0];
            nx_wd = nx_rd;
          end
          fl_we   = 1'b1;
          fl_wa   = cur_q[IW-1:0];
          fl_wd   = 1'b1;
          done_d  = 1'b1;
          rsp_d   = '{status: ffca_pkg::ST_GRANTED, user_offset: user_off(cur_q)};
          state_d = S_IDLE;
        end else begin
          pred_d  = cur_q;
          cur_d   = nx_rd;
          state_d = S_A_RD;
        end
      end

      S_A_SPL: begin
        sz_we = 1'b1;
        sz_wa = cur_q[IW-1:0];
        sz_wd = SW'(need_q);
        if (pred_q == ffca_pkg::LIST_END) begin
          head_d = rest_q;
        end else begin
          nx_we = 1'b1;
          nx_wa = pred_q[IW-1:0];
          nx_wd = rest_q;
        end
        done_d  = 1'b1;
        rsp_d   = '{status: ffca_pkg::ST_GRANTED, user_offset: user_off(cur_q)};
        state_d = S_IDLE;
      end

      S_F_CHK: begin
        if (!fl_rd) begin
          done_d  = 1'b1;
          rsp_d   = '{status: ffca_pkg::ST_IGNORED, user_offset: '0};
          state_d = S_IDLE;
        end else begin
          fl_we   = 1'b1;
          fl_wa   = g_q[IW-1:0];
          fl_wd   = 1'b0;
          cur_d   = head_q;
          pred_d  = ffca_pkg::LIST_END;
          state_d = S_F_RD;
        end
      end

      S_F_RD: begin
        if (cur_q == ffca_pkg::LIST_END || cur_q >= g_q) begin
          state_d = S_F_INS;
        end else begin
          rd_idx  = cur_q[IW-1:0];
          state_d = S_F_NX;
        end
      end

      S_F_NX: begin
        pred_d  = cur_q;
        cur_d   = nx_rd;
        state_d = S_F_RD;
      end

      S_F_INS: begin
        nx_we   = 1'b1;
        nx_wa   = g_q[IW-1:0];
        nx_wd   = cur_q;
        rd_idx  = g_q[IW-1:0];
        state_d = S_F_LNK;
      end

      S_F_LNK: begin
        szg_d = sz_rd;
        if (pred_q == ffca_pkg::LIST_END) begin
          head_d = g_q;
        end else begin
          nx_we = 1'b1;
          nx_wa = pred_q[IW-1:0];
          nx_wd = g_q;
        end
        rd_idx  = pred_q[IW-1:0];
        state_d = S_F_MP;
      end

      S_F_MP: begin
        // merge with the block in front
        if (pred_q != ffca_pkg::LIST_END && 32'(pred_q) + 32'(sz_rd) == 32'(g_q)) begin
          sz_we = 1'b1;
          sz_wa = pred_q[IW-1:0];
          sz_wd = sz_rd + szg_q;
          nx_we = 1'b1;
          nx_wa = pred_q[IW-1:0];
          nx_wd = cur_q;
          g_d   = pred_q;
          szg_d = sz_rd + szg_q;
        end
        rd_idx  = cur_q[IW-1:0];
        state_d = S_F_MC;
      end

      S_F_MC: begin
        // merge with the block behind
        if (cur_q != ffca_pkg::LIST_END && 32'(g_q) + 32'(szg_q) == 32'(cur_q)) begin
          sz_we = 1'b1;
          sz_wa = g_q[IW-1:0];
          sz_wd = szg_q + sz_rd;
          nx_we = 1'b1;
          nx_wa = g_q[IW-1:0];
          nx_wd = nx_rd;
        end
        done_d  = 1'b1;
        rsp_d   = '{status: ffca_pkg::ST_FREED, user_offset: '0};
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (sz_we) begin
      size_mem[sz_wa] <= sz_wd;
    end
    if (nx_we) begin
      next_mem[nx_wa] <= nx_wd;
    end
    if (fl_we) begin
      flag_mem[fl_wa] <= fl_wd;
    end
    sz_rd <= size_mem[rd_idx];
    nx_rd <= next_mem[rd_idx];
    fl_rd <= flag_mem[rd_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      cnt_q   <= '0;
      head_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      head_q  <= head_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    pred_q <= pred_d;
    g_q    <= g_d;
    rest_q <= rest_d;
    need_q <= need_d;
    szg_q  <= szg_d;
    rsp_q  <= rsp_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ----- hdl/ffca_checker.sv -----
// port-level checker for the first-fit coalescing allocator, with its bind
// depends on ffca_pkg and first_fit_coalescing_allocator
`timescale 1ns / 1ps

module ffca_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input ffca_pkg::rsp_t rsp_o
);

  // an accepted item either finishes at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || done_o)
    else $error("accepted item neither answered nor in progress");

  // no answer while idle without a request having been taken
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(start && !busy) && !$past(busy) && $past(rst_ni) |-> !done_o)
    else $error("response item without a request");

  // only a grant carries an offset
  a_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status != ffca_pkg::ST_GRANTED |-> rsp_o.user_offset == '0)
    else $error("non-zero offset on a non-grant");

  // a grant points one header past a granule-aligned block
  a_offset_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status == ffca_pkg::ST_GRANTED |->
      rsp_o.user_offset[ffca_pkg::GRAN_SHIFT-1:0] == '0 && rsp_o.user_offset != '0)
    else $error("granted offset not aligned");

endmodule

bind first_fit_coalescing_allocator ffca_checker u_ffca_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);
